/* hdl/etqp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etqp_pkg
// Shared types and result codes of the event task priority queue.
// ----------------------------------------------------------------------------
package etqp_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int KIND_W     = 3;
  localparam int SLOT_FLD_W = 3;

  localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NULL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  // One table entry as held in the RAM.
  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  ident;
    logic [15:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

/* hdl/event_task_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_task_priority_queue
// Table of event-triggered tasks with insert and priority dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser selects the operation, 0 insert, 1 schedule
//   point. An insert stores handle, ident and priority in the lowest free
//   slot and returns one result (inserted, dropped full, or null ignored for
//   a zero handle). A schedule point returns one dispatch transfer for every
//   occupied slot whose priority is at least running_prio, in slot order,
//   freeing each one, then a done transfer with tlast high.
//   Output stream (m_*): m_tuser carries the result kind, m_tlast marks the
//   final transfer of an item.
//   Timing: an insert result is registered and shown in the cycle after its
//   input transfer. A schedule point walks the table through the entry RAM
//   slot by slot (read, then check), then a done state; output stalls pause
//   it. One item is in work at a time; the next input transfer is taken once
//   the table walk is over and the output register can take a result.
//   Reset: the valid bits clear at once, so the table is empty; RAM contents
//   are left as they are. A stalled receiver holds the output register and
//   pauses the walk on the next qualifying slot.
// ----------------------------------------------------------------------------
module event_task_priority_queue
  import etqp_pkg::*;
#(
  parameter int NUM_SLOTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] task_handle, [23:16] task_ident, [31:24] task_prio,
  // [39:32] running_prio
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [2:0] slot, [18:3] out_handle, [26:19] out_ident, [34:27] out_prio,
  // [39:35] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [2:0] kind
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  state_t              state;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [SLOT_W-1:0]   idx;
  logic [7:0]          running_prio;

  // Output register.
  logic                  out_valid;
  logic [KIND_W-1:0]     out_kind;
  logic [SLOT_FLD_W-1:0] out_slot;
  logic [15:0]           out_handle;
  logic [7:0]            out_ident;
  logic [7:0]            out_prio;
  logic                  out_last;

  // Input fields.
  logic [15:0] in_handle;
  logic [7:0]  in_ident;
  logic [7:0]  in_prio;
  logic [7:0]  in_running;

  assign in_handle  = s_tdata[15:0];
  assign in_ident   = s_tdata[23:16];
  assign in_prio    = s_tdata[31:24];
  assign in_running = s_tdata[39:32];

  logic out_free;
  logic in_xfer;
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_xfer  = s_tvalid && s_tready;

  // Lowest free slot.
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Entry RAM: written on insert, read one slot at a time during a walk.
  logic   ram_we;
  entry_t ram_wdata;
  entry_t ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  assign ram_we = in_xfer && (s_tuser == OP_INSERT) && (in_handle != 16'd0) && free_found;
  assign ram_wdata = '{prio: in_prio, ident: in_ident, handle: in_handle};
  assign ram_rdata = entry_t'(ram_rdata_raw);

  etqp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata_raw)
  );

  // A slot qualifies when occupied and its priority reaches the running one.
  logic hit;
  assign hit = slot_valid[idx] && (ram_rdata.prio >= running_prio);

  // Which result to load this cycle.
  logic load_insert;
  logic load_dispatch;
  logic load_done;
  assign load_insert   = in_xfer && (s_tuser == OP_INSERT);
  assign load_dispatch = (state == ST_CHECK) && hit && out_free;
  assign load_done     = (state == ST_DONE) && out_free;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (load_insert || load_dispatch || load_done) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (ram_we) begin
            slot_valid[free_idx] <= 1'b1;
          end
          if (in_xfer && (s_tuser == OP_SCHEDULE)) begin
            idx   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          // Hold on a qualifying slot until the output register frees up.
          if (!hit || out_free) begin
            if (hit) begin
              slot_valid[idx] <= 1'b0;
            end
            if (idx == LAST_SLOT) begin
              state <= ST_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      running_prio <= in_running;
    end
    if (load_insert) begin
      out_handle <= 16'd0;
      out_ident  <= 8'd0;
      out_prio   <= 8'd0;
      out_last   <= 1'b1;
      if (in_handle == 16'd0) begin
        out_kind <= KIND_NULL;
        out_slot <= '0;
      end else if (free_found) begin
        out_kind <= KIND_INSERTED;
        out_slot <= SLOT_FLD_W'(free_idx);
      end else begin
        out_kind <= KIND_FULL;
        out_slot <= '0;
      end
    end else if (load_dispatch) begin
      out_kind   <= KIND_DISPATCH;
      out_slot   <= SLOT_FLD_W'(idx);
      out_handle <= ram_rdata.handle;
      out_ident  <= ram_rdata.ident;
      out_prio   <= ram_rdata.prio;
      out_last   <= 1'b0;
    end else if (load_done) begin
      out_kind   <= KIND_DONE;
      out_slot   <= '0;
      out_handle <= 16'd0;
      out_ident  <= 8'd0;
      out_prio   <= 8'd0;
      out_last   <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, out_prio, out_ident, out_handle, out_slot};

endmodule

/* hdl/etqp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etqp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etqp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* bench/tb_event_task_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_task_priority_queue
// Self-checking bench for the event task priority queue. A driver streams
// insert and schedule-point items from a pending queue in random bursts. A
// monitor predicts the results of every accepted item with its own copy of
// the task table and checks every output transfer against them in order.
// The receiver stalls on its own pattern and holds off once for a long run.
// ----------------------------------------------------------------------------
module tb_event_task_priority_queue;
  import etqp_pkg::*;

  localparam int NUM_SLOTS   = 6;
  localparam int CLK_HALF    = 4;
  localparam int RANDOM_ITEMS = 213;
  // Latency of one full table walk plus margin, used for the final drain.
  localparam int DRAIN_CYCLES = 4 * (2 * NUM_SLOTS + 1);
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_TRIGGER = 60;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic        op;
    logic [15:0] handle;
    logic [7:0]  ident;
    logic [7:0]  prio;
    logic [7:0]  running;
  } task_item_t;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [SLOT_FLD_W-1:0] slot;
    logic [15:0]           handle;
    logic [7:0]            ident;
    logic [7:0]            prio;
    logic                  last;
  } queue_result_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SLOW,
    RX_PERIODIC
  } rx_mode_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  // Items waiting for the driver; the head is the one on the bus.
  task_item_t    pending_items[$];
  // Results predicted for accepted items, oldest first.
  queue_result_t expected_results[$];
  int            error_count = 0;

  // Shadow copy of the task table.
  logic        shadow_busy[NUM_SLOTS];
  logic [15:0] shadow_handle[NUM_SLOTS];
  logic [7:0]  shadow_ident[NUM_SLOTS];
  logic [7:0]  shadow_prio[NUM_SLOTS];

  event_task_priority_queue #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("tb_event_task_priority_queue NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void push_result(input logic [KIND_W-1:0] kind,
                                      input int slot_num,
                                      input logic [15:0] handle,
                                      input logic [7:0] ident,
                                      input logic [7:0] prio,
                                      input logic last);
    queue_result_t res;
    res.kind   = kind;
    res.slot   = SLOT_FLD_W'(slot_num);
    res.handle = handle;
    res.ident  = ident;
    res.prio   = prio;
    res.last   = last;
    expected_results.push_back(res);
  endfunction

  // Apply one accepted item to the shadow table and queue what it answers.
  function automatic void predict_task_results(input logic op,
                                               input logic [15:0] handle,
                                               input logic [7:0] ident,
                                               input logic [7:0] prio,
                                               input logic [7:0] running);
    bit placed;
    placed = 1'b0;
    if (op == OP_INSERT) begin
      if (handle == 16'd0) begin
        // Null handle answers null ignored, full table or not.
        push_result(KIND_NULL, 0, 16'd0, 8'd0, 8'd0, 1'b1);
      end else begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !shadow_busy[i]) begin
            shadow_busy[i]   = 1'b1;
            shadow_handle[i] = handle;
            shadow_ident[i]  = ident;
            shadow_prio[i]   = prio;
            push_result(KIND_INSERTED, i, 16'd0, 8'd0, 8'd0, 1'b1);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          push_result(KIND_FULL, 0, 16'd0, 8'd0, 8'd0, 1'b1);
        end
      end
    end else begin
      // Walk in slot order, dispatch and free every entry at or above running.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (shadow_busy[i] && shadow_prio[i] >= running) begin
          push_result(KIND_DISPATCH, i, shadow_handle[i], shadow_ident[i],
                      shadow_prio[i], 1'b0);
          shadow_busy[i] = 1'b0;
        end
      end
      push_result(KIND_DONE, 0, 16'd0, 8'd0, 8'd0, 1'b1);
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want,
               got);
      error_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check the output transfer first, since it always belongs to an
  // older item, then predict for the input transfer of the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                   $time, m_tuser, m_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind",   16'(want.kind),   16'(m_tuser));
          check_field("slot",   16'(want.slot),   16'(m_tdata[2:0]));
          check_field("handle", want.handle,      m_tdata[18:3]);
          check_field("ident",  16'(want.ident),  16'(m_tdata[26:19]));
          check_field("prio",   16'(want.prio),   16'(m_tdata[34:27]));
          check_field("last",   16'(want.last),   16'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_task_results(s_tuser, s_tdata[15:0], s_tdata[23:16],
                             s_tdata[31:24], s_tdata[39:32]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. Hold the bus while a
  // transfer is stalled; advance the queue once it is taken.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    task_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        void'(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
        end
        item = pending_items[0];
        s_tvalid <= 1'b1;
        s_tuser  <= item.op;
        s_tdata  <= {item.running, item.prio, item.ident, item.handle};
        burst_left--;
        if (burst_left == 0) begin
          // Half of the bursts run straight into the next one.
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches at random among free, coin, slow and periodic modes.
  // Once enough results are taken, hold off for a long stretch so the table
  // walk and the input both back up.
  // --------------------------------------------------------------------------
  int       taken_count = 0;
  int       hold_left   = 0;
  bit       hold_done   = 1'b0;
  int       mode_left   = 0;
  int       phase_count = 0;
  rx_mode_t rx_mode     = RX_FREE;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        taken_count++;
      end
      phase_count++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && taken_count >= HOLD_TRIGGER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:     m_tready <= 1'b1;
          RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
          RX_SLOW:     m_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: m_tready <= (phase_count % 3 != 0);
          default:     m_tready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic op, input logic [15:0] handle,
                            input logic [7:0] ident, input logic [7:0] prio,
                            input logic [7:0] running);
    task_item_t item;
    item.op      = op;
    item.handle  = handle;
    item.ident   = ident;
    item.prio    = prio;
    item.running = running;
    pending_items.push_back(item);
  endtask

  initial begin
    int pick;
    logic [7:0] running;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_busy[i] = 1'b0;
    end

    // Directed part.
    // Schedule point on an empty table: done only.
    queue_item(OP_SCHEDULE, 16'hFFFF, 8'hFF, 8'hFF, 8'd0);
    // Null handle on an empty table.
    queue_item(OP_INSERT, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    // Fill every slot with extreme fields.
    queue_item(OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 8'h00);
    queue_item(OP_INSERT, 16'h0001, 8'h00, 8'h00, 8'hFF);
    queue_item(OP_INSERT, 16'h8000, 8'h80, 8'h7F, 8'h00);
    queue_item(OP_INSERT, 16'h7FFF, 8'h7F, 8'h80, 8'h00);
    queue_item(OP_INSERT, 16'hA5A5, 8'h5A, 8'hFE, 8'h00);
    queue_item(OP_INSERT, 16'h5A5A, 8'hA5, 8'h01, 8'h00);
    // Table full: dropped, then null still answers null ignored.
    queue_item(OP_INSERT, 16'h1234, 8'h12, 8'h34, 8'h00);
    queue_item(OP_INSERT, 16'd0, 8'h00, 8'h00, 8'h00);
    // Highest running priority takes only priority 255.
    queue_item(OP_SCHEDULE, 16'h0000, 8'h00, 8'h00, 8'hFF);
    // Refill the freed slot, then dispatch the upper half.
    queue_item(OP_INSERT, 16'h0F0F, 8'h33, 8'hC0, 8'h00);
    queue_item(OP_SCHEDULE, 16'h0000, 8'h00, 8'h00, 8'h80);
    // Lowest free slot is reused after a partial dispatch.
    queue_item(OP_INSERT, 16'hBEEF, 8'h44, 8'h10, 8'hFF);
    queue_item(OP_INSERT, 16'h0002, 8'h55, 8'h90, 8'hFF);
    // Running priority 0 empties everything.
    queue_item(OP_SCHEDULE, 16'hFFFF, 8'hFF, 8'hFF, 8'h00);
    // Empty again: done only.
    queue_item(OP_SCHEDULE, 16'h0000, 8'h00, 8'h00, 8'h00);

    // Random part: mostly real inserts, schedule points now and then, a few
    // null handles. Unused fields carry random content.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        case ($urandom_range(0, 5))
          0:       running = 8'h00;
          1:       running = 8'hFF;
          2:       running = 8'($urandom_range(0, 63));
          default: running = 8'($urandom);
        endcase
        queue_item(OP_SCHEDULE, 16'($urandom), 8'($urandom), 8'($urandom),
                   running);
      end else if (pick < 36) begin
        queue_item(OP_INSERT, 16'd0, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        queue_item(OP_INSERT, 16'($urandom_range(1, 65535)), 8'($urandom),
                   8'($urandom), 8'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then let the monitor catch up.
    while (pending_items.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_event_task_priority_queue OK");
    end else begin
      $display("tb_event_task_priority_queue NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/etqp_pkg.sv
hdl/etqp_ram.sv
hdl/event_task_priority_queue.sv
bench/tb_event_task_priority_queue.sv
